### src/nnr_pkg.sv
// Shared types, constants and helpers of the nearest-neighbor image remapper.
package nnr_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 128;
    localparam int PIXEL_BITS  = 24;
    localparam int FRAC_BITS   = 12;

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_CNT_W   = ADDR_W + 1;
    localparam int ROW_W       = 7;
    localparam int COL_W       = 7;
    localparam int SIZE_W      = 8;
    localparam int STEP_W      = 16;
    localparam int OFFSET_W    = 21;
    localparam int PROD_W      = STEP_W + ROW_W + 1;
    localparam int V_W         = PROD_W + 1;
    localparam int Q_W         = V_W - 1 - FRAC_BITS;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = OFFSET_W;

    // Command queue between front and back; depth is a power of two.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_ROWS    = 3'd0,
        REG_IN_COLS    = 3'd1,
        REG_OUT_ROWS   = 3'd2,
        REG_OUT_COLS   = 3'd3,
        REG_ROW_STEP   = 3'd4,
        REG_ROW_OFFSET = 3'd5,
        REG_COL_STEP   = 3'd6,
        REG_COL_OFFSET = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                  kind;
        logic [PIXEL_BITS-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic [ROW_W-1:0]      out_row;
        logic [COL_W-1:0]      out_col;
        logic                  last;
    } out_item_t;

    // One frame-memory operation, in item order.
    typedef struct packed {
        logic                  is_read;
        logic [ADDR_W-1:0]     addr;
        logic [PIXEL_BITS-1:0] pixel;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic                  last;
    } cmd_t;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    // Size register as used: zero acts as one, oversize acts as the maximum.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > max_v)
            r = max_v;
        else
            r = v;
        return r;
    endfunction

endpackage

### src/nnr_front.sv
// Front end: config registers, input acceptance, counters and address mapping.
module nnr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  nnr_pkg::in_item_t           item,
    input  logic                        cfg_we,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [nnr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  nnr_pkg::q_status_t          q_status,
    output logic                        q_push,
    output nnr_pkg::cmd_t               q_cmd
);
    import nnr_pkg::*;

    logic [SIZE_W-1:0]    in_rows_reg, in_rows_next;
    logic [SIZE_W-1:0]    in_cols_reg, in_cols_next;
    logic [SIZE_W-1:0]    out_rows_reg, out_rows_next;
    logic [SIZE_W-1:0]    out_cols_reg, out_cols_next;
    logic [STEP_W-1:0]    row_step_reg, row_step_next;
    logic [OFFSET_W-1:0]  row_offset_reg, row_offset_next;
    logic [STEP_W-1:0]    col_step_reg, col_step_next;
    logic [OFFSET_W-1:0]  col_offset_reg, col_offset_next;
    logic [PIX_CNT_W-1:0] pix_count_reg, pix_count_next;

    logic [ADDR_W-1:0]    load_index_reg, load_index_next;
    logic [ROW_W-1:0]     scan_row_reg, scan_row_next;
    logic [COL_W-1:0]     scan_col_reg, scan_col_next;

    logic                  s1_valid_reg;
    logic                  s1_kind_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [ADDR_W-1:0]     s1_load_addr_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_last_reg;
    logic signed [V_W-1:0] s1_vrow_reg, s1_vcol_reg;

    logic                  accept;
    logic [Q_CNT_W:0]      occupancy;
    logic [PIX_CNT_W-1:0]  load_inc;
    logic                  col_end, row_end;
    logic signed [PROD_W-1:0] prod_row, prod_col;
    logic signed [V_W-1:0] vrow, vcol;
    logic [ROW_W-1:0]      src_row;
    logic [COL_W-1:0]      src_col;
    logic [2*SIZE_W-1:0]   size_prod;
    logic [ROW_W+SIZE_W-1:0] rd_base;

    function automatic logic [ROW_W-1:0] clamp_coord(input logic signed [V_W-1:0] v,
                                                     input logic [SIZE_W-1:0] size);
        logic [Q_W-1:0]   q;
        logic [ROW_W-1:0] r;
        q = v[V_W-2:FRAC_BITS];
        if (v[V_W-1])
            r = '0;
        else if (q >= Q_W'(size))
            r = ROW_W'(size - SIZE_W'(1));
        else
            r = q[ROW_W-1:0];
        return r;
    endfunction

    // Configuration writes; the used sizes and the pixel count are kept ready.
    always_comb
    begin
        in_rows_next    = in_rows_reg;
        in_cols_next    = in_cols_reg;
        out_rows_next   = out_rows_reg;
        out_cols_next   = out_cols_reg;
        row_step_next   = row_step_reg;
        row_offset_next = row_offset_reg;
        col_step_next   = col_step_reg;
        col_offset_next = col_offset_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_IN_ROWS:    in_rows_next    = eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(MAX_ROWS));
                REG_IN_COLS:    in_cols_next    = eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(MAX_COLS));
                REG_OUT_ROWS:   out_rows_next   = eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(MAX_ROWS));
                REG_OUT_COLS:   out_cols_next   = eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(MAX_COLS));
                REG_ROW_STEP:   row_step_next   = cfg_data[STEP_W-1:0];
                REG_ROW_OFFSET: row_offset_next = cfg_data[OFFSET_W-1:0];
                REG_COL_STEP:   col_step_next   = cfg_data[STEP_W-1:0];
                REG_COL_OFFSET: col_offset_next = cfg_data[OFFSET_W-1:0];
                default:        ;
            endcase
        end
        size_prod      = in_rows_next * in_cols_next;
        pix_count_next = size_prod[PIX_CNT_W-1:0];
    end

    // Reserve a queue slot for every item in flight.
    assign occupancy = (Q_CNT_W+1)'(q_status.count) + (Q_CNT_W+1)'(s1_valid_reg);
    assign full      = occupancy >= (Q_CNT_W+1)'(Q_DEPTH);
    assign accept    = push && !full;

    assign col_end  = ({1'b0, scan_col_reg} + SIZE_W'(1)) >= out_cols_reg;
    assign row_end  = ({1'b0, scan_row_reg} + SIZE_W'(1)) >= out_rows_reg;
    assign load_inc = PIX_CNT_W'(load_index_reg) + PIX_CNT_W'(1);

    assign prod_row = $signed(row_step_reg) * $signed({1'b0, scan_row_reg});
    assign prod_col = $signed(col_step_reg) * $signed({1'b0, scan_col_reg});
    assign vrow = {prod_row[PROD_W-1], prod_row}
                + {{(V_W-OFFSET_W){row_offset_reg[OFFSET_W-1]}}, row_offset_reg};
    assign vcol = {prod_col[PROD_W-1], prod_col}
                + {{(V_W-OFFSET_W){col_offset_reg[OFFSET_W-1]}}, col_offset_reg};

    always_comb
    begin
        load_index_next = load_index_reg;
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        if (accept)
        begin
            if (!item.kind)
            begin
                if (load_inc >= pix_count_reg)
                    load_index_next = '0;
                else
                    load_index_next = load_inc[ADDR_W-1:0];
            end
            else if (col_end)
            begin
                scan_col_next = '0;
                scan_row_next = row_end ? '0 : scan_row_reg + ROW_W'(1);
            end
            else
            begin
                scan_col_next = scan_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rows_reg    <= SIZE_W'(MAX_ROWS);
            in_cols_reg    <= SIZE_W'(MAX_COLS);
            out_rows_reg   <= SIZE_W'(MAX_ROWS);
            out_cols_reg   <= SIZE_W'(MAX_COLS);
            row_step_reg   <= STEP_W'(1 << FRAC_BITS);
            row_offset_reg <= '0;
            col_step_reg   <= STEP_W'(1 << FRAC_BITS);
            col_offset_reg <= '0;
            pix_count_reg  <= PIX_CNT_W'(STORE_DEPTH);
            load_index_reg <= '0;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            in_rows_reg    <= in_rows_next;
            in_cols_reg    <= in_cols_next;
            out_rows_reg   <= out_rows_next;
            out_cols_reg   <= out_cols_next;
            row_step_reg   <= row_step_next;
            row_offset_reg <= row_offset_next;
            col_step_reg   <= col_step_next;
            col_offset_reg <= col_offset_next;
            pix_count_reg  <= pix_count_next;
            load_index_reg <= load_index_next;
            scan_row_reg   <= scan_row_next;
            scan_col_reg   <= scan_col_next;
            s1_valid_reg   <= accept;
        end
    end

    // Stage one payload: raw fixed-point coordinates and the load address.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg      <= item.kind;
            s1_pixel_reg     <= item.pixel_in;
            s1_load_addr_reg <= load_index_reg;
            s1_row_reg       <= scan_row_reg;
            s1_col_reg       <= scan_col_reg;
            s1_last_reg      <= col_end && row_end;
            s1_vrow_reg      <= vrow;
            s1_vcol_reg      <= vcol;
        end
    end

    // Stage two: truncate, clamp and form the raster address.
    assign src_row = clamp_coord(s1_vrow_reg, in_rows_reg);
    assign src_col = clamp_coord(s1_vcol_reg, in_cols_reg);
    assign rd_base = src_row * in_cols_reg;

    always_comb
    begin
        q_push        = s1_valid_reg;
        q_cmd.is_read = s1_kind_reg;
        q_cmd.addr    = s1_kind_reg ? (rd_base[ADDR_W-1:0] + ADDR_W'(src_col))
                                    : s1_load_addr_reg;
        q_cmd.pixel   = s1_pixel_reg;
        q_cmd.row     = s1_row_reg;
        q_cmd.col     = s1_col_reg;
        q_cmd.last    = s1_last_reg;
    end

`ifndef SYNTHESIS
    a_front_credit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_status.count < Q_CNT_W'(Q_DEPTH)))
        else $error("front pushed without a reserved queue slot");
`endif

endmodule

### src/nnr_queue.sv
// Short command queue that decouples the front end from the frame memory.
module nnr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_push,
    input  nnr_pkg::cmd_t      q_cmd,
    input  logic               q_pop,
    output nnr_pkg::cmd_t      q_head,
    output nnr_pkg::q_status_t q_status
);
    import nnr_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            entry_reg[wr_ptr_reg] <= q_cmd;
    end

    assign q_head         = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;

`ifndef SYNTHESIS
    a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |-> (count_reg < Q_CNT_W'(Q_DEPTH)))
        else $error("command queue overflow");
    a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("command queue underflow");
`endif

endmodule

### src/nnr_back.sv
// Back end: frame memory, executes queued stores and fetches in order.
module nnr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  nnr_pkg::q_status_t q_status,
    input  nnr_pkg::cmd_t      q_head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output nnr_pkg::out_item_t result
);
    import nnr_pkg::*;

    logic [PIXEL_BITS-1:0] frame_mem [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  last_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free, rd_issue, wr_issue;

    // A fetch goes only when its result has a place to land.
    assign out_free = !out_valid_reg || pop;
    assign rd_issue = !q_status.empty && q_head.is_read && out_free;
    assign wr_issue = !q_status.empty && !q_head.is_read;
    assign q_pop    = rd_issue || wr_issue;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rd_issue)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_issue)
            frame_mem[q_head.addr] <= q_head.pixel;
        if (rd_issue)
        begin
            rd_data_reg <= frame_mem[q_head.addr];
            row_reg     <= q_head.row;
            col_reg     <= q_head.col;
            last_reg    <= q_head.last;
        end
    end

    assign empty            = !out_valid_reg;
    assign result.pixel_out = rd_data_reg;
    assign result.out_row   = row_reg;
    assign result.out_col   = col_reg;
    assign result.last      = last_reg;

`ifndef SYNTHESIS
    a_fetch_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rd_issue |=> out_valid_reg)
        else $error("fetched pixel not presented");
`endif

endmodule

### src/nearest_neighbor_image_remap.sv
// Top level of the nearest-neighbor image remapper.
//
// Both sides look like a queue. A word pushed with kind 0 stores pixel_in
// into the frame memory at the next raster position of the input image
// (in_rows x in_cols, wrapping after the last pixel). A word pushed with
// kind 1 produces one result word: the next pixel of the out_rows x out_cols
// output image in raster order, fetched from the source position given by
// the per-axis map src = step * idx + offset (step signed Q4.12, offset
// signed Q9.12), truncated and clamped to the input bounds; last marks the
// final pixel of the image. Use step -1.0 with offset size-1 for a flip and
// step 1/factor with offset 0 for scaling. Sustained rate is one word per
// cycle on both sides while results are popped. A result passes through the
// map stage, the command queue and the registered frame-memory read
// before it sits on the result ports. full rises once four words sit
// between the front end and the memory, which happens only while results
// are not being popped. The frame memory has no reset: fetch only pixels
// that were stored. Write configuration only while idle.
module nearest_neighbor_image_remap (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  nnr_pkg::in_item_t              item,
    output logic                           empty,
    input  logic                           pop,
    output nnr_pkg::out_item_t             result,
    input  logic                           cfg_we,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [nnr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nnr_pkg::*;

    q_status_t q_status;
    cmd_t      q_cmd;
    cmd_t      q_head;
    logic      q_push;
    logic      q_pop;

    // Accept words, advance counters, map coordinates.
    nnr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // Hold memory commands in arrival order.
    nnr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .q_status (q_status)
    );

    // Store and fetch pixels, present results.
    nnr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

### sim/tb_nearest_neighbor_image_remap.sv
// Self-checking testbench for the nearest-neighbor image remapper.
module tb_nearest_neighbor_image_remap;
    import nnr_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    // Stores have no result, so give them room to reach the frame memory too.
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 1650;
    localparam int IDLE_PCT      = 9;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_EMIT  = 1'b1;

    localparam logic [STEP_W-1:0]   STEP_ONE       = STEP_W'(1 << FRAC_BITS);
    localparam logic [STEP_W-1:0]   STEP_MINUS_ONE = STEP_W'(-(1 << FRAC_BITS));
    localparam logic [STEP_W-1:0]   STEP_MAX       = 16'h7FFF;
    localparam logic [STEP_W-1:0]   STEP_MIN       = 16'h8000;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX     = 21'h0FFFFF;
    localparam logic [OFFSET_W-1:0] OFFSET_MIN     = 21'h100000;

    typedef enum int {
        MAP_IDENTITY,
        MAP_FLIP,
        MAP_SCALE,
        MAP_SCALE_CENTERED,
        MAP_EXTREME,
        MAP_RANDOM
    } map_mode_t;

    // DUT ports; every input starts at a known value.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  push     = 1'b0;
    logic                  full;
    in_item_t              item     = '0;
    logic                  empty;
    logic                  pop      = 1'b0;
    out_item_t             result;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the configuration registers, starting at their reset values.
    logic [SIZE_W-1:0]          sz_in_rows  = 8'd128;
    logic [SIZE_W-1:0]          sz_in_cols  = 8'd128;
    logic [SIZE_W-1:0]          sz_out_rows = 8'd128;
    logic [SIZE_W-1:0]          sz_out_cols = 8'd128;
    logic signed [STEP_W-1:0]   row_step    = STEP_ONE;
    logic signed [OFFSET_W-1:0] row_offset  = '0;
    logic signed [STEP_W-1:0]   col_step    = STEP_ONE;
    logic signed [OFFSET_W-1:0] col_offset  = '0;

    // Predictor state: advanced only when the DUT accepts a word.
    logic [PIXEL_BITS-1:0] frame_copy [STORE_DEPTH];
    int                    load_pos = 0;
    int                    scan_r   = 0;
    int                    scan_c   = 0;
    out_item_t             pixels_due [$];

    // Planner state: advanced when a word is queued, so that an emit word is
    // only ever queued for a source pixel that has been stored since reset.
    bit       written [STORE_DEPTH];
    int       plan_load = 0;
    int       plan_r    = 0;
    int       plan_c    = 0;
    in_item_t pending [$];

    int err_count    = 0;
    int cycle_count  = 0;
    int idle_pct     = IDLE_PCT;
    int words_queued = 0;
    int emits_queued = 0;
    int results_seen = 0;
    int map_settings = 0;

    nearest_neighbor_image_remap i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Size as the block uses it: zero acts as one, oversize acts as the maximum.
    function automatic int clip_size(logic [SIZE_W-1:0] v, int max_v);
        if (v == '0)
            return 1;
        return (int'(v) > max_v) ? max_v : int'(v);
    endfunction

    // One axis of the map: truncate the fixed-point coordinate, clamp to the image.
    function automatic int map_axis(logic signed [STEP_W-1:0] step,
                                    logic signed [OFFSET_W-1:0] offset,
                                    int idx, int size);
        longint pos;
        pos = longint'(step) * idx + longint'(offset);
        if (pos < 0)
            return 0;
        pos = pos >>> FRAC_BITS;
        return (pos >= size) ? size - 1 : int'(pos);
    endfunction

    function automatic int source_addr(int r, int c);
        int ic;
        ic = clip_size(sz_in_cols, MAX_COLS);
        return map_axis(row_step, row_offset, r, clip_size(sz_in_rows, MAX_ROWS)) * ic
             + map_axis(col_step, col_offset, c, ic);
    endfunction

    // Load position after one store; an index past a shrunken image wraps too.
    function automatic int next_load(int pos);
        int npix;
        npix = clip_size(sz_in_rows, MAX_ROWS) * clip_size(sz_in_cols, MAX_COLS);
        return (pos + 1 >= npix) ? 0 : pos + 1;
    endfunction

    // Advance the raster scan of the output image by one pixel.
    task automatic advance_scan(inout int r, inout int c);
        int orows;
        int ocols;
        orows = clip_size(sz_out_rows, MAX_ROWS);
        ocols = clip_size(sz_out_cols, MAX_COLS);
        if (c + 1 >= ocols)
        begin
            c = 0;
            r = (r + 1 >= orows) ? 0 : r + 1;
        end
        else
            c = c + 1;
    endtask

    // Apply one accepted word to the predictor; an emit word owes one result.
    task automatic predict_word(in_item_t w);
        out_item_t px;
        if (w.kind == KIND_STORE)
        begin
            frame_copy[load_pos] = w.pixel_in;
            load_pos = next_load(load_pos);
        end
        else
        begin
            px.pixel_out = frame_copy[source_addr(scan_r, scan_c)];
            px.out_row   = ROW_W'(scan_r);
            px.out_col   = COL_W'(scan_c);
            px.last      = (scan_c + 1 >= clip_size(sz_out_cols, MAX_COLS))
                        && (scan_r + 1 >= clip_size(sz_out_rows, MAX_ROWS));
            pixels_due.push_back(px);
            advance_scan(scan_r, scan_c);
        end
    endtask

    // Compare one popped result word against the oldest expected pixel.
    task automatic check_pixel(out_item_t got);
        out_item_t want;
        results_seen++;
        if (pixels_due.size() == 0)
        begin
            $error("unexpected result word: pixel_out %h out_row %0d out_col %0d last %0b",
                   got.pixel_out, got.out_row, got.out_col, got.last);
            err_count++;
        end
        else
        begin
            want = pixels_due.pop_front();
            if (got.pixel_out !== want.pixel_out)
            begin
                $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
                err_count++;
            end
            if (got.out_row !== want.out_row)
            begin
                $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                err_count++;
            end
            if (got.out_col !== want.out_col)
            begin
                $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                err_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                err_count++;
            end
        end
    endtask

    // Queue one word. An emit whose source pixel was never stored turns into a
    // store, which also fills the frame further.
    task automatic queue_word(bit want_emit, logic [PIXEL_BITS-1:0] pix);
        in_item_t w;
        w.pixel_in = pix;
        if (want_emit && written[source_addr(plan_r, plan_c)])
        begin
            w.kind = KIND_EMIT;
            advance_scan(plan_r, plan_c);
            emits_queued++;
        end
        else
        begin
            w.kind = KIND_STORE;
            written[plan_load] = 1'b1;
            plan_load = next_load(plan_load);
        end
        pending.push_back(w);
        words_queued++;
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_IN_ROWS:    sz_in_rows  = val[SIZE_W-1:0];
            REG_IN_COLS:    sz_in_cols  = val[SIZE_W-1:0];
            REG_OUT_ROWS:   sz_out_rows = val[SIZE_W-1:0];
            REG_OUT_COLS:   sz_out_cols = val[SIZE_W-1:0];
            REG_ROW_STEP:   row_step    = val[STEP_W-1:0];
            REG_ROW_OFFSET: row_offset  = val[OFFSET_W-1:0];
            REG_COL_STEP:   col_step    = val[STEP_W-1:0];
            default:        col_offset  = val[OFFSET_W-1:0];
        endcase
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Hold the sender until every queued word is in and every result is out,
    // then let stores still in the pipe reach the frame memory.
    task automatic drain_and_settle();
        while (pending.size() != 0 || push || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Mostly small images, with zero, exactly the maximum and oversize mixed in.
    function automatic logic [SIZE_W-1:0] rand_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 8)
            return SIZE_W'($urandom_range(129, 255));
        if (roll < 11)
            return SIZE_W'(MAX_ROWS);
        if (roll < 30)
            return SIZE_W'($urandom_range(9, 24));
        return SIZE_W'($urandom_range(1, 8));
    endfunction

    // Pick a map for one axis: the usual software settings plus raw extremes.
    task automatic pick_axis(int in_size, int out_size,
                             output logic [STEP_W-1:0] step,
                             output logic [OFFSET_W-1:0] offset);
        int ratio;
        ratio = (in_size << FRAC_BITS) / out_size;
        if (ratio > int'(STEP_MAX))
            ratio = int'(STEP_MAX);
        case (map_mode_t'($urandom_range(0, 5)))
            MAP_IDENTITY:
            begin
                step   = STEP_ONE;
                offset = '0;
            end
            MAP_FLIP:
            begin
                step   = STEP_MINUS_ONE;
                offset = OFFSET_W'((in_size - 1) << FRAC_BITS);
            end
            MAP_SCALE:
            begin
                step   = STEP_W'(ratio);
                offset = '0;
            end
            MAP_SCALE_CENTERED:
            begin
                step   = STEP_W'(ratio);
                offset = OFFSET_W'(ratio / 2);
            end
            MAP_EXTREME:
            begin
                case ($urandom_range(0, 2))
                    0:       step = STEP_MAX;
                    1:       step = STEP_MIN;
                    default: step = '0;
                endcase
                case ($urandom_range(0, 2))
                    0:       offset = OFFSET_MAX;
                    1:       offset = OFFSET_MIN;
                    default: offset = '0;
                endcase
            end
            default:
            begin
                step   = STEP_W'($urandom);
                offset = OFFSET_W'($urandom);
            end
        endcase
    endtask

    // One random setting: load an image, scan the output image, add some noise.
    task automatic random_phase();
        logic [STEP_W-1:0]   rs;
        logic [STEP_W-1:0]   cs;
        logic [OFFSET_W-1:0] ro;
        logic [OFFSET_W-1:0] co;
        int npix;
        int nout;
        write_reg(REG_IN_ROWS, CFG_DATA_W'(rand_size()));
        write_reg(REG_IN_COLS, CFG_DATA_W'(rand_size()));
        write_reg(REG_OUT_ROWS, CFG_DATA_W'(rand_size()));
        write_reg(REG_OUT_COLS, CFG_DATA_W'(rand_size()));
        pick_axis(clip_size(sz_in_rows, MAX_ROWS), clip_size(sz_out_rows, MAX_ROWS), rs, ro);
        pick_axis(clip_size(sz_in_cols, MAX_COLS), clip_size(sz_out_cols, MAX_COLS), cs, co);
        write_reg(REG_ROW_STEP, CFG_DATA_W'(rs));
        write_reg(REG_ROW_OFFSET, CFG_DATA_W'(ro));
        write_reg(REG_COL_STEP, CFG_DATA_W'(cs));
        write_reg(REG_COL_OFFSET, CFG_DATA_W'(co));
        map_settings++;

        npix = clip_size(sz_in_rows, MAX_ROWS) * clip_size(sz_in_cols, MAX_COLS);
        nout = clip_size(sz_out_rows, MAX_ROWS) * clip_size(sz_out_cols, MAX_COLS);
        if (npix > 48)
            npix = 48;
        if (nout > 60)
            nout = 60;
        // Most of the time a whole frame; sometimes a broken, partial load.
        if ($urandom_range(0, 3) == 0)
            npix = $urandom_range(0, npix);
        repeat (npix) queue_word(1'b0, rand_pixel());
        repeat (nout) queue_word($urandom_range(0, 99) < 88, rand_pixel());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 20)) queue_word($urandom_range(0, 1), rand_pixel());
    endtask

    // Sender: hold a word while full, advance on acceptance, idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
                predict_word(item);
            if (!push || !full)
            begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    item <= pending.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: check every popped word, stall pop at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_pixel(result);
            pop <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Stop a hung run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("run timed out after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int target;
        int phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // One-row image of four pixels (row count zero acts as one); store the
        // extreme pixel values, then scan past the end of the image to wrap.
        write_reg(REG_IN_ROWS, '0);
        write_reg(REG_IN_COLS, CFG_DATA_W'(4));
        write_reg(REG_OUT_ROWS, CFG_DATA_W'(1));
        write_reg(REG_OUT_COLS, CFG_DATA_W'(4));
        write_reg(REG_ROW_STEP, CFG_DATA_W'(STEP_ONE));
        write_reg(REG_ROW_OFFSET, '0);
        write_reg(REG_COL_STEP, CFG_DATA_W'(STEP_ONE));
        write_reg(REG_COL_OFFSET, '0);
        queue_word(1'b0, 24'h000000);
        queue_word(1'b0, 24'hFFFFFF);
        queue_word(1'b0, 24'hAAAAAA);
        queue_word(1'b0, 24'h555555);
        repeat (6) queue_word(1'b1, rand_pixel());
        drain_and_settle();

        // Horizontal flip, starting mid-row.
        write_reg(REG_COL_STEP, CFG_DATA_W'(STEP_MINUS_ONE));
        write_reg(REG_COL_OFFSET, CFG_DATA_W'(3 << FRAC_BITS));
        repeat (4) queue_word(1'b1, rand_pixel());
        drain_and_settle();

        // Oversize row count, extreme steps and offsets: the row coordinate goes
        // negative and the column one past the edge. Output width zero acts as
        // one, so the column counter sits beyond the shrunken width.
        write_reg(REG_IN_ROWS, CFG_DATA_W'(255));
        write_reg(REG_OUT_ROWS, CFG_DATA_W'(255));
        write_reg(REG_OUT_COLS, '0);
        write_reg(REG_ROW_STEP, CFG_DATA_W'(STEP_MIN));
        write_reg(REG_ROW_OFFSET, CFG_DATA_W'(OFFSET_MIN));
        write_reg(REG_COL_STEP, CFG_DATA_W'(STEP_MAX));
        write_reg(REG_COL_OFFSET, CFG_DATA_W'(OFFSET_MAX));
        repeat (3) queue_word(1'b1, rand_pixel());
        drain_and_settle();

        // Shrink the input image in the middle of a load: the next store still
        // lands at the old position before the index wraps. Shrink the output
        // image below the scan row as well.
        write_reg(REG_IN_ROWS, CFG_DATA_W'(1));
        repeat (2) queue_word(1'b0, rand_pixel());
        drain_and_settle();
        write_reg(REG_IN_COLS, CFG_DATA_W'(1));
        write_reg(REG_OUT_ROWS, CFG_DATA_W'(1));
        write_reg(REG_OUT_COLS, CFG_DATA_W'(1));
        write_reg(REG_ROW_STEP, CFG_DATA_W'(STEP_ONE));
        write_reg(REG_ROW_OFFSET, '0);
        write_reg(REG_COL_STEP, CFG_DATA_W'(STEP_ONE));
        write_reg(REG_COL_OFFSET, '0);
        repeat (2) queue_word(1'b0, rand_pixel());
        queue_word(1'b1, rand_pixel());
        drain_and_settle();

        // Random settings; each ends with the sender held until all results are
        // back. A run of settings goes without any idling on either side.
        target = words_queued + RANDOM_WORDS;
        phase  = 0;
        while (words_queued < target)
        begin
            idle_pct = (phase >= 6 && phase < 11) ? 0 : IDLE_PCT;
            random_phase();
            drain_and_settle();
            phase++;
        end

        $display("Sent %0d words (%0d pixel requests) under %0d random map settings;",
                 words_queued, emits_queued, map_settings);
        $display("checked %0d result words against the predicted pixels.", results_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
src/nnr_pkg.sv
src/nnr_front.sv
src/nnr_queue.sv
src/nnr_back.sv
src/nearest_neighbor_image_remap.sv
sim/tb_nearest_neighbor_image_remap.sv
